@@ hdl/abcc_pkg.sv @@
// Shared types and constants of the alpha blend and colour key compositor.
`timescale 1ns / 1ps

package abcc_pkg;

    localparam int NUM_KEYS    = 4;
    localparam int KEY_IDX_W   = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int Q_PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int Q_LEVEL_W   = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    localparam logic [CFG_INDEX_W-1:0] CFG_BPP       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_COUNT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_FIRST = 3'd2;

    localparam logic [2:0] BPP_RESET = 3'd4;
    localparam logic [2:0] BPP_MIN   = 3'd1;
    localparam logic [2:0] BPP_MAX   = 3'd4;
    localparam logic [2:0] BPP_KEYED = 3'd3;

    localparam logic [1:0] OP_SKIP  = 2'd0;
    localparam logic [1:0] OP_COPY  = 2'd1;
    localparam logic [1:0] OP_BLEND = 2'd2;

    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
    localparam logic [7:0] ALPHA_CLEAR  = 8'd0;

    typedef struct packed {
        logic [7:0] src_red;
        logic [7:0] src_green;
        logic [7:0] src_blue;
        logic [7:0] src_alpha;
        logic [7:0] dst_red;
        logic [7:0] dst_green;
        logic [7:0] dst_blue;
        logic [7:0] dst_alpha;
    } pixel_t;

    typedef struct packed {
        logic       write_enable;
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
    } result_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  alpha;
        logic [23:0] src_rgb;
        logic [23:0] dst_rgb;
        logic [31:0] base;
    } job_t;

    typedef struct packed {
        logic [Q_LEVEL_W-1:0] level;
        logic                 full;
    } q_status_t;

endpackage

@@ hdl/abcc_front.sv @@
// Front end: configuration registers, pixel acceptance and classification.
`timescale 1ns / 1ps

module abcc_front
    import abcc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   pixel_valid,
    output logic                   pixel_ready,
    input  pixel_t                 pixel,
    output logic                   job_valid,
    input  logic                   job_ready,
    output job_t                   job
);

    logic [2:0]  bpp_reg;
    logic [2:0]  key_count_reg;
    logic [23:0] key_reg [NUM_KEYS];
    logic        valid_reg;
    job_t        job_reg;
    job_t        job_next;

    logic [2:0]            bpp;
    logic [2:0]            nkeys;
    logic [23:0]           dkey;
    logic                  hit;
    logic                  skip;
    logic                  copy;
    logic [CFG_INDEX_W-1:0] key_sel;

    assign key_sel = cfg_index - CFG_KEY_FIRST;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpp_reg       <= BPP_RESET;
            key_count_reg <= '0;
            for (int i = 0; i < NUM_KEYS; i++)
            begin
                key_reg[i] <= '0;
            end
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_BPP)
            begin
                bpp_reg <= cfg_data[2:0];
            end
            else if (cfg_index == CFG_KEY_COUNT)
            begin
                key_count_reg <= cfg_data[2:0];
            end
            else if (cfg_index >= CFG_KEY_FIRST &&
                     {1'b0, key_sel} < (CFG_INDEX_W + 1)'(NUM_KEYS))
            begin
                key_reg[key_sel[KEY_IDX_W-1:0]] <= cfg_data[23:0];
            end
        end
    end

    always_comb
    begin
        bpp = bpp_reg;
        if (bpp_reg < BPP_MIN)
        begin
            bpp = BPP_MIN;
        end
        else if (bpp_reg > BPP_MAX)
        begin
            bpp = BPP_MAX;
        end
        nkeys = (key_count_reg > 3'(NUM_KEYS)) ? 3'(NUM_KEYS) : key_count_reg;
        dkey  = {pixel.dst_blue, pixel.dst_green, pixel.dst_red};
        hit   = 1'b0;
        for (int i = 0; i < NUM_KEYS; i++)
        begin
            if (3'(i) < nkeys && key_reg[i] == dkey)
            begin
                hit = 1'b1;
            end
        end
        skip = (bpp == BPP_MAX && pixel.src_alpha == ALPHA_CLEAR) ||
               (bpp >= BPP_KEYED && hit);
        copy = (bpp <= BPP_KEYED) || (pixel.src_alpha == ALPHA_OPAQUE);

        job_next.alpha   = pixel.src_alpha;
        job_next.src_rgb = {pixel.src_blue, pixel.src_green, pixel.src_red};
        job_next.dst_rgb = dkey;
        job_next.base    = {pixel.dst_alpha, pixel.dst_blue, pixel.dst_green, pixel.dst_red};
        if (skip)
        begin
            job_next.op = OP_SKIP;
        end
        else if (copy)
        begin
            job_next.op = OP_COPY;
            job_next.base[7:0] = pixel.src_red;
            if (bpp >= 3'd2)
            begin
                job_next.base[15:8] = pixel.src_green;
            end
            if (bpp >= 3'd3)
            begin
                job_next.base[23:16] = pixel.src_blue;
            end
            if (bpp >= 3'd4)
            begin
                job_next.base[31:24] = pixel.src_alpha;
            end
        end
        else
        begin
            job_next.op = OP_BLEND;
        end
    end

    assign pixel_ready = !valid_reg || job_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pixel_ready)
        begin
            valid_reg <= pixel_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pixel_ready && pixel_valid)
        begin
            job_reg <= job_next;
        end
    end

    assign job_valid = valid_reg;
    assign job       = job_reg;

endmodule

@@ hdl/abcc_queue.sv @@
// Short queue of classified items between the front and back ends.
`timescale 1ns / 1ps

module abcc_queue
    import abcc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push_valid,
    output logic      push_ready,
    input  job_t      push_job,
    output logic      pop_valid,
    input  logic      pop_ready,
    output job_t      pop_job,
    output q_status_t status
);

    job_t                 mem [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_LEVEL_W-1:0] level_reg;
    logic                 push;
    logic                 pop;

    assign push_ready = level_reg < Q_LEVEL_W'(QUEUE_DEPTH);
    assign pop_valid  = level_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_job    = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                level_reg <= level_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                level_reg <= level_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    assign status.level = level_reg;
    assign status.full  = !push_ready;

endmodule

@@ hdl/abcc_back.sv @@
// Back end: blend arithmetic in two stages, the product stage and the result register.
`timescale 1ns / 1ps

module abcc_back
    import abcc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    job_valid,
    output logic    job_ready,
    input  job_t    job,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    logic        s1_valid_reg;
    logic [1:0]  s1_op_reg;
    logic [31:0] s1_base_reg;
    logic [15:0] s1_sum_reg [3];
    logic [15:0] s1_sum_next [3];

    logic        out_valid_reg;
    result_t     out_reg;
    result_t     out_next;

    logic        out_free;
    logic [7:0]  inv_alpha;
    logic [16:0] q_wide [3];

    assign inv_alpha = ALPHA_OPAQUE - job.alpha;
    assign out_free  = !out_valid_reg || result_ready;
    assign job_ready = !s1_valid_reg || out_free;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            s1_sum_next[c] = ({8'd0, job.alpha} * {8'd0, job.src_rgb[8*c +: 8]}) +
                             ({8'd0, inv_alpha} * {8'd0, job.dst_rgb[8*c +: 8]});
        end
    end

    // floor(x / 255) for x up to 255 * 255 without a divider.
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            q_wide[c] = {1'b0, s1_sum_reg[c]} + 17'd1 + {9'd0, s1_sum_reg[c][15:8]};
        end
        out_next.write_enable = s1_op_reg != OP_SKIP;
        if (s1_op_reg == OP_BLEND)
        begin
            out_next.out_red   = q_wide[0][15:8];
            out_next.out_green = q_wide[1][15:8];
            out_next.out_blue  = q_wide[2][15:8];
            out_next.out_alpha = ALPHA_OPAQUE;
        end
        else
        begin
            out_next.out_red   = s1_base_reg[7:0];
            out_next.out_green = s1_base_reg[15:8];
            out_next.out_blue  = s1_base_reg[23:16];
            out_next.out_alpha = s1_base_reg[31:24];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (job_ready)
            begin
                s1_valid_reg <= job_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_ready && job_valid)
        begin
            s1_op_reg   <= job.op;
            s1_base_reg <= job.base;
            for (int c = 0; c < 3; c++)
            begin
                s1_sum_reg[c] <= s1_sum_next[c];
            end
        end
        if (out_free && s1_valid_reg)
        begin
            out_reg <= out_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

@@ hdl/alpha_blend_color_key_compositor.sv @@
// Top level of the per-pixel alpha blend and colour key compositor.
// Each item on the pixel channel carries a source and a destination RGBA pixel;
// each item on the result channel carries a write enable and the new pixel.
// Both channels use valid and ready; an item moves when both are high.
// The configuration channel writes one register per item: index 0 is bytes
// per pixel, 1 the key count and 2 to 5 the protected colours. It is always
// ready and is only to be written while no pixel item is in flight.
// A pixel item passes a classification register, a two-entry queue, a stage
// holding the alpha products and the result register, in that order. While
// result_ready is high, one item is accepted and one result delivered per
// cycle; the products are formed by one multiplier pair per colour channel
// ahead of the product stage.
// When the receiver stalls, the result register, the product stage and the
// queue fill in turn before pixel_ready falls, so the front and back ends
// hold their items independently.
// Reset empties every stage and the queue and restores four bytes per pixel,
// no keys in use and all protected colours at zero.
`timescale 1ns / 1ps

module alpha_blend_color_key_compositor
    import abcc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   pixel_valid,
    output logic                   pixel_ready,
    input  pixel_t                 pixel,
    output logic                   result_valid,
    input  logic                   result_ready,
    output result_t                result
);

    logic      front_valid;
    logic      front_ready;
    job_t      front_job;
    logic      back_valid;
    logic      back_ready;
    job_t      back_job;
    q_status_t q_status;

    assign cfg_ready = 1'b1;

    abcc_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .pixel       (pixel),
        .job_valid   (front_valid),
        .job_ready   (front_ready),
        .job         (front_job)
    );

    abcc_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_job   (front_job),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_job    (back_job),
        .status     (q_status)
    );

    abcc_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (back_valid),
        .job_ready    (back_ready),
        .job          (back_job),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // The queue never holds more items than it has entries.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_status.level <= Q_LEVEL_W'(QUEUE_DEPTH))
        else $error("queue level above its depth");

    // An accepted pixel item is held in the front register on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && pixel_ready |=> front_valid)
        else $error("accepted item lost in the front end");

    // A full queue with a waiting classified item must stall the pixel channel.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_status.full && front_valid |-> !pixel_ready)
        else $error("pixel accepted while the front end is blocked");

    // A stalled front item must remain in place.
    assert property (@(posedge clk) disable iff (!rst_n)
        front_valid && !front_ready |=> front_valid && $stable(front_job))
        else $error("front item changed while stalled");

endmodule
